>>> design/lcd_scanline_mode_timer_unit_macros.svh
// Assertion macros used by the checker file of the scanline timer.
`ifndef LCD_SCANLINE_MODE_TIMER_UNIT_MACROS_SVH
`define LCD_SCANLINE_MODE_TIMER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define LSMT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define LSMT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/lsmt_pkg.sv
`timescale 1ns / 1ps

package lsmt_pkg;

   localparam int CLK_W  = 13;
   localparam int THR_W  = 11;
   localparam int LINE_W = 8;
   localparam int CNT_W  = 7;

   localparam logic [THR_W-1:0] T_OAM       = 11'd82;
   localparam logic [THR_W-1:0] T_XFER      = 11'd252;
   localparam logic [THR_W-1:0] T_LINE      = 11'd456;
   localparam logic [THR_W-1:0] T_LINE_HEAD = 11'd448;
   localparam logic [THR_W-1:0] T_LINE_TAIL = 11'd8;
   localparam logic [THR_W-1:0] T_HBL_WAIT  = 11'd4;

   localparam logic [LINE_W-1:0] LINE_VBL   = 8'd144;
   localparam logic [LINE_W-1:0] LINE_SHORT = 8'd153;
   localparam logic [LINE_W-1:0] LINE_WRAP  = 8'd154;

   localparam logic [9:0]       NO_EVENT  = 10'd1023;
   localparam logic [9:0]       HBL_EVENT = 10'd4;
   localparam logic [CNT_W-1:0] MAX_TRANS = 7'd64;

   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_OAM    = 2'd2;
   localparam logic [1:0] MODE_XFER   = 2'd3;

   localparam logic REQ_ADVANCE = 1'b0;
   localparam logic REQ_ENABLE  = 1'b1;

   localparam logic REG_DOUBLE_SPEED = 1'b0;

   typedef struct packed {
      logic       req_type;
      logic [7:0] clock_increment;
      logic       lcd_enable;
   } req_word_type;

   typedef struct packed {
      logic [1:0] screen_mode;
      logic [7:0] current_line;
      logic       draw_valid;
      logic [7:0] draw_line;
      logic       vblank_request;
      logic       frame_done;
      logic       stat_flag_clear;
      logic       line_changed;
      logic [9:0] clocks_to_next;
   } rsp_word_type;

   function automatic logic [THR_W-1:0] thr(input logic [THR_W-1:0] base, input logic ds);
      return base << ds;
   endfunction

endpackage

>>> design/lsmt_req_if.sv
`timescale 1ns / 1ps

interface lsmt_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] clock_increment;
   logic       lcd_enable;

   modport source (output valid, output req_type, output clock_increment,
                   output lcd_enable, input ready);
   modport sink (input valid, input req_type, input clock_increment,
                 input lcd_enable, output ready);
endinterface

>>> design/lsmt_rsp_if.sv
`timescale 1ns / 1ps

interface lsmt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] screen_mode;
   logic [7:0] current_line;
   logic       draw_valid;
   logic [7:0] draw_line;
   logic       vblank_request;
   logic       frame_done;
   logic       stat_flag_clear;
   logic       line_changed;
   logic [9:0] clocks_to_next;

   modport source (output valid, output screen_mode, output current_line,
                   output draw_valid, output draw_line, output vblank_request,
                   output frame_done, output stat_flag_clear, output line_changed,
                   output clocks_to_next, input ready);
   modport sink (input valid, input screen_mode, input current_line,
                 input draw_valid, input draw_line, input vblank_request,
                 input frame_done, input stat_flag_clear, input line_changed,
                 input clocks_to_next, output ready);
endinterface

>>> design/lsmt_seq.sv
`timescale 1ns / 1ps

module lsmt_seq
   import lsmt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         double_speed,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_STEP = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [1:0]        mode_ff, mode_in;
   logic [7:0]        line_ff, line_in;
   logic [CLK_W-1:0]  clocks_ff, clocks_in;
   logic              drawn_ff, drawn_in;
   logic              lcd_on_ff, lcd_on_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              dv_ff, dv_in;
   logic [7:0]        dl_ff, dl_in;
   logic              vbl_ff, vbl_in;
   logic              frame_ff, frame_in;
   logic              sclr_ff, sclr_in;
   logic              lchg_ff, lchg_in;
   rsp_word_type      out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   logic [THR_W-1:0]  thr_sel;
   logic [THR_W-1:0]  delta_thr;
   logic [CLK_W-1:0]  operand;
   logic [CLK_W-1:0]  sum;
   logic              ge;
   logic              go;
   logic              start;
   logic              out_free;
   logic [7:0]        line_nxt;
   logic [9:0]        diff;
   logic [9:0]        to_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign start     = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign line_nxt  = line_ff + 8'd1;

   // Shared compare and add unit: one threshold and one addend per cycle.
   always_comb begin
      thr_sel   = '0;
      delta_thr = thr(T_LINE, double_speed);
      unique case (mode_ff)
         MODE_OAM:    thr_sel = thr(T_OAM, double_speed);
         MODE_XFER:   thr_sel = thr(T_XFER, double_speed);
         MODE_VBLANK: begin
            thr_sel = thr(T_LINE, double_speed);
            if (line_ff != '0) begin
               if (line_nxt == LINE_SHORT) begin
                  delta_thr = thr(T_LINE_TAIL, double_speed);
               end else if (line_nxt == LINE_WRAP) begin
                  delta_thr = thr(T_LINE_HEAD, double_speed);
               end
            end
         end
         default:     thr_sel = drawn_ff ? thr(T_LINE, double_speed) : T_HBL_WAIT;
      endcase
      unique case (state_ff)
         ST_IDLE: operand = {{(CLK_W-8){1'b0}}, req_word.clock_increment};
         ST_STEP: operand = CLK_W'(0) - {{(CLK_W-THR_W){1'b0}}, delta_thr};
         default: operand = '0;
      endcase
   end

   assign ge   = clocks_ff >= {{(CLK_W-THR_W){1'b0}}, thr_sel};
   assign sum  = clocks_ff + operand;
   assign go   = ge && (cnt_ff != MAX_TRANS);
   assign diff = 10'(thr_sel - clocks_ff[THR_W-1:0]);

   always_comb begin
      if (!lcd_on_ff) begin
         to_next = NO_EVENT;
      end else if (mode_ff == MODE_OAM || mode_ff == MODE_VBLANK) begin
         to_next = ge ? 10'd0 : diff;
      end else begin
         to_next = HBL_EVENT;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      line_in      = line_ff;
      clocks_in    = clocks_ff;
      drawn_in     = drawn_ff;
      lcd_on_in    = lcd_on_ff;
      cnt_in       = cnt_ff;
      dv_in        = dv_ff;
      dl_in        = dl_ff;
      vbl_in       = vbl_ff;
      frame_in     = frame_ff;
      sclr_in      = sclr_ff;
      lchg_in      = lchg_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dv_in    = 1'b0;
               dl_in    = '0;
               vbl_in   = 1'b0;
               frame_in = 1'b0;
               sclr_in  = 1'b0;
               lchg_in  = 1'b0;
               cnt_in   = '0;
               state_in = ST_OUT;
               if (req_word.req_type == REQ_ENABLE) begin
                  if (req_word.lcd_enable != lcd_on_ff) begin
                     lchg_in   = (line_ff != '0);
                     line_in   = '0;
                     clocks_in = req_word.lcd_enable ? {{(CLK_W-THR_W){1'b0}}, T_LINE} : '0;
                     mode_in   = req_word.lcd_enable ? MODE_VBLANK : MODE_HBLANK;
                     sclr_in   = 1'b1;
                  end
                  lcd_on_in = req_word.lcd_enable;
               end else if (lcd_on_ff) begin
                  clocks_in = sum;
                  state_in  = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            if (go) begin
               cnt_in = cnt_ff + 7'd1;
               unique case (mode_ff)
                  MODE_OAM: mode_in = MODE_XFER;
                  MODE_XFER: begin
                     dv_in    = 1'b1;
                     dl_in    = line_ff;
                     mode_in  = MODE_HBLANK;
                     drawn_in = 1'b1;
                  end
                  MODE_HBLANK: begin
                     if (!drawn_ff) begin
                        if (line_ff == LINE_VBL) begin
                           mode_in = MODE_VBLANK;
                           vbl_in  = 1'b1;
                        end else begin
                           mode_in = MODE_OAM;
                        end
                     end else begin
                        clocks_in = sum;
                        line_in   = line_nxt;
                        drawn_in  = 1'b0;
                        lchg_in   = 1'b1;
                     end
                  end
                  default: begin
                     clocks_in = sum;
                     if (line_ff == '0) begin
                        mode_in = MODE_OAM;
                     end else begin
                        lchg_in = 1'b1;
                        if (line_nxt == LINE_WRAP) begin
                           line_in  = '0;
                           frame_in = 1'b1;
                        end else begin
                           line_in = line_nxt;
                        end
                     end
                  end
               endcase
            end else begin
               clocks_in = {{(CLK_W-THR_W){1'b0}}, clocks_ff[THR_W-1:0]};
               state_in  = ST_OUT;
            end
         end
         default: begin
            if (out_free) begin
               out_in.screen_mode     = mode_ff;
               out_in.current_line    = line_ff;
               out_in.draw_valid      = dv_ff;
               out_in.draw_line       = dl_ff;
               out_in.vblank_request  = vbl_ff;
               out_in.frame_done      = frame_ff;
               out_in.stat_flag_clear = sclr_ff;
               out_in.line_changed    = lchg_ff;
               out_in.clocks_to_next  = to_next;
               out_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_HBLANK;
         line_ff      <= '0;
         clocks_ff    <= '0;
         drawn_ff     <= 1'b0;
         lcd_on_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         line_ff      <= line_in;
         clocks_ff    <= clocks_in;
         drawn_ff     <= drawn_in;
         lcd_on_ff    <= lcd_on_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      dv_ff    <= dv_in;
      dl_ff    <= dl_in;
      vbl_ff   <= vbl_in;
      frame_ff <= frame_in;
      sclr_ff  <= sclr_in;
      lchg_ff  <= lchg_in;
      out_ff   <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

endmodule

>>> design/lcd_scanline_mode_timer_unit.sv
`timescale 1ns / 1ps

// Scanline and mode timer of a handheld color LCD controller.
// The req channel takes one word per item: either an advance by an increment
// of 0 to 255 or a write of the LCD enable bit. The rsp channel returns exactly
// one word per item with the mode, the line, the events of the item and the
// clocks to the next mode event. The double_speed register sits at byte
// address 0 of the APB port and may only be written while the block is idle.
// An advance is added to the line clock at the accepting edge; then the shared
// compare and add unit takes its mode transitions one at a time in the STEP
// state, a closing step follows, and the OUT state loads the output register.
// An enable write, or an advance while the LCD is off, goes straight from
// acceptance to the OUT state. req is ready again as soon as the word is
// loaded, so a new item is not taken before the last one is loaded.
// The output register holds the word while rsp is stalled; a following item
// is accepted and worked on meanwhile and waits in the OUT state until the
// register is free. Synchronous reset turns the LCD off, clears the line,
// mode and line clock state, empties the output register and sets
// double_speed to 0.

module lcd_scanline_mode_timer_unit
   import lsmt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lsmt_req_if.sink    req,
   lsmt_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic         double_speed_ff, double_speed_in;
   logic         csr_write;
   logic         csr_hit;
   req_word_type req_word;
   rsp_word_type rsp_word;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == REG_DOUBLE_SPEED);
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = csr_hit ? {31'b0, double_speed_ff} : 32'b0;

   always_comb begin
      double_speed_in = double_speed_ff;
      if (csr_write && csr_hit) begin
         double_speed_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         double_speed_ff <= 1'b0;
      end else begin
         double_speed_ff <= double_speed_in;
      end
   end

   assign req_word.req_type        = req.req_type;
   assign req_word.clock_increment = req.clock_increment;
   assign req_word.lcd_enable      = req.lcd_enable;

   lsmt_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .double_speed (double_speed_ff),
      .req_valid    (req.valid),
      .req_ready    (req.ready),
      .req_word     (req_word),
      .rsp_valid    (rsp.valid),
      .rsp_ready    (rsp.ready),
      .rsp_word     (rsp_word)
   );

   assign rsp.screen_mode     = rsp_word.screen_mode;
   assign rsp.current_line    = rsp_word.current_line;
   assign rsp.draw_valid      = rsp_word.draw_valid;
   assign rsp.draw_line       = rsp_word.draw_line;
   assign rsp.vblank_request  = rsp_word.vblank_request;
   assign rsp.frame_done      = rsp_word.frame_done;
   assign rsp.stat_flag_clear = rsp_word.stat_flag_clear;
   assign rsp.line_changed    = rsp_word.line_changed;
   assign rsp.clocks_to_next  = rsp_word.clocks_to_next;

endmodule

>>> design/lsmt_checker.sv
`timescale 1ns / 1ps
`include "lcd_scanline_mode_timer_unit_macros.svh"

module lsmt_checker
   import lsmt_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] screen_mode,
   input logic [7:0] current_line,
   input logic       draw_valid,
   input logic       vblank_request,
   input logic       frame_done,
   input logic       stat_flag_clear,
   input logic [9:0] clocks_to_next
);

   `LSMT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(screen_mode) && $stable(current_line) && $stable(clocks_to_next),
      "rsp word changed while stalled")

   `LSMT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
      "req ready right after an accepted word")

   `LSMT_ASSERT_NOW(a_off_state, rsp_valid && clocks_to_next == NO_EVENT,
      screen_mode == MODE_HBLANK && current_line == 8'd0,
      "LCD off but mode or line not cleared")

   `LSMT_ASSERT_NOW(a_toggle_alone, rsp_valid && stat_flag_clear,
      !draw_valid && !vblank_request && !frame_done && current_line == 8'd0,
      "enable toggle reported with timing events")

endmodule

bind lcd_scanline_mode_timer_unit lsmt_checker u_lsmt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .screen_mode     (rsp.screen_mode),
   .current_line    (rsp.current_line),
   .draw_valid      (rsp.draw_valid),
   .vblank_request  (rsp.vblank_request),
   .frame_done      (rsp.frame_done),
   .stat_flag_clear (rsp.stat_flag_clear),
   .clocks_to_next  (rsp.clocks_to_next)
);

>>> verif/tb_lcd_scanline_mode_timer_unit.sv
`timescale 1ns / 1ps

module tb_lcd_scanline_mode_timer_unit;
   import lsmt_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int NUM_PHASES  = 5;
   localparam int PHASE_ITEMS = 370;
   localparam int LONG_HOLD   = 400;
   localparam int DRAIN_TAIL  = 16;

   typedef enum logic {ROW_WORD, ROW_DOUBLE_SPEED} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_word_type word;
      logic         speed;
      logic         typed;
      rsp_word_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   lsmt_req_if req_bus();
   lsmt_rsp_if rsp_bus();

   lcd_scanline_mode_timer_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predicted timer state.
   logic        pred_double = 1'b0;
   logic [1:0]  pred_mode   = MODE_HBLANK;
   logic [7:0]  pred_line   = 8'd0;
   int unsigned pred_clocks = 0;
   logic        pred_drawn  = 1'b0;
   logic        pred_lcd_on = 1'b0;

   rsp_word_type expected_status[$];
   stim_row_type dir_rows[$];

   int failures      = 0;
   int words_checked = 0;
   int draws_seen    = 0;
   int vblanks_seen  = 0;
   int frames_seen   = 0;
   int toggles_seen  = 0;
   int hold_requests = 0;
   int cycle_count   = 0;
   logic idling      = 1'b1;

   function automatic int unsigned scaled(input logic [THR_W-1:0] base);
      return pred_double ? (32'(base) << 1) : 32'(base);
   endfunction

   function automatic logic [9:0] clocks_to_event();
      int unsigned limit;
      if (!pred_lcd_on) return NO_EVENT;
      case (pred_mode)
         MODE_OAM:    limit = scaled(T_OAM);
         MODE_VBLANK: limit = scaled(T_LINE);
         default:     return HBL_EVENT;
      endcase
      return (pred_clocks >= limit) ? 10'd0 : 10'(limit - pred_clocks);
   endfunction

   function automatic rsp_word_type predict_status(input req_word_type w);
      rsp_word_type r;
      logic         moved;
      r = '0;
      if (w.req_type == REQ_ENABLE) begin
         if (w.lcd_enable != pred_lcd_on) begin
            r.line_changed = (pred_line != 8'd0);
            pred_line = 8'd0;
            if (w.lcd_enable) begin
               pred_clocks = 32'(T_LINE);
               pred_mode   = MODE_VBLANK;
            end else begin
               pred_clocks = 0;
               pred_mode   = MODE_HBLANK;
            end
            r.stat_flag_clear = 1'b1;
            toggles_seen++;
         end
         pred_lcd_on = w.lcd_enable;
      end else if (pred_lcd_on) begin
         pred_clocks += 32'(w.clock_increment);
         for (int n = 0; n < MAX_TRANS; n++) begin
            moved = 1'b0;
            case (pred_mode)
               MODE_OAM: begin
                  if (pred_clocks >= scaled(T_OAM)) begin
                     pred_mode = MODE_XFER;
                     moved     = 1'b1;
                  end
               end
               MODE_XFER: begin
                  if (pred_clocks >= scaled(T_XFER)) begin
                     r.draw_valid = 1'b1;
                     r.draw_line  = pred_line;
                     pred_mode    = MODE_HBLANK;
                     pred_drawn   = 1'b1;
                     moved        = 1'b1;
                  end
               end
               MODE_HBLANK: begin
                  if (!pred_drawn) begin
                     if (pred_clocks >= T_HBL_WAIT) begin
                        if (pred_line == LINE_VBL) begin
                           pred_mode        = MODE_VBLANK;
                           r.vblank_request = 1'b1;
                        end else begin
                           pred_mode = MODE_OAM;
                        end
                        moved = 1'b1;
                     end
                  end else if (pred_clocks >= scaled(T_LINE)) begin
                     pred_clocks   -= scaled(T_LINE);
                     pred_line      = pred_line + 8'd1;
                     pred_drawn     = 1'b0;
                     r.line_changed = 1'b1;
                     moved          = 1'b1;
                  end
               end
               default: begin
                  if (pred_clocks >= scaled(T_LINE)) begin
                     pred_clocks -= scaled(T_LINE);
                     moved        = 1'b1;
                     if (pred_line == 8'd0) begin
                        pred_mode = MODE_OAM;
                     end else begin
                        pred_line      = pred_line + 8'd1;
                        r.line_changed = 1'b1;
                        if (pred_line == LINE_SHORT) begin
                           pred_clocks += scaled(T_LINE_HEAD);
                        end else if (pred_line == LINE_WRAP) begin
                           pred_line    = 8'd0;
                           r.frame_done = 1'b1;
                           pred_clocks += scaled(T_LINE_TAIL);
                        end
                     end
                  end
               end
            endcase
            if (!moved) break;
         end
         pred_clocks &= 32'h7FF;
      end
      r.screen_mode    = pred_mode;
      r.current_line   = pred_line;
      r.clocks_to_next = clocks_to_event();
      draws_seen      += int'(r.draw_valid);
      vblanks_seen    += int'(r.vblank_request);
      frames_seen     += int'(r.frame_done);
      return r;
   endfunction

   function automatic rsp_word_type status(input logic [1:0] mode, input logic [7:0] line,
                                           input logic sclear, input logic lchg,
                                           input logic [9:0] wait_clocks);
      rsp_word_type r;
      r                 = '0;
      r.screen_mode     = mode;
      r.current_line    = line;
      r.stat_flag_clear = sclear;
      r.line_changed    = lchg;
      r.clocks_to_next  = wait_clocks;
      return r;
   endfunction

   function automatic stim_row_type word_row(input logic kind_bit, input int incr,
                                             input logic en, input logic typed,
                                             input rsp_word_type want);
      stim_row_type row;
      row.kind                 = ROW_WORD;
      row.word.req_type        = kind_bit;
      row.word.clock_increment = 8'(incr);
      row.word.lcd_enable      = en;
      row.speed                = 1'b0;
      row.typed                = typed;
      row.want                 = want;
      return row;
   endfunction

   function automatic stim_row_type speed_row(input logic value);
      stim_row_type row;
      row       = word_row(REQ_ADVANCE, 0, 1'b0, 1'b0, '0);
      row.kind  = ROW_DOUBLE_SPEED;
      row.speed = value;
      return row;
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      w.clock_increment = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(192, 255))
                                                     : 8'($urandom);
      w.lcd_enable = 1'($urandom_range(0, 1));
      if (!pred_lcd_on) begin
         w.req_type = ($urandom_range(0, 3) == 0) ? REQ_ADVANCE : REQ_ENABLE;
         if (w.req_type == REQ_ENABLE) w.lcd_enable = ($urandom_range(0, 3) != 0);
      end else begin
         w.req_type = ($urandom_range(0, 199) == 0) ? REQ_ENABLE : REQ_ADVANCE;
      end
      return w;
   endfunction

   task automatic check_field(input string name, input logic [9:0] want_v,
                              input logic [9:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         failures++;
      end
   endtask

   task automatic check_result();
      rsp_word_type want;
      if (expected_status.size() == 0) begin
         $error("result word arrived with nothing pending");
         failures++;
         return;
      end
      want = expected_status.pop_front();
      words_checked++;
      check_field("screen_mode", 10'(want.screen_mode), 10'(rsp_bus.screen_mode));
      check_field("current_line", 10'(want.current_line), 10'(rsp_bus.current_line));
      check_field("draw_valid", 10'(want.draw_valid), 10'(rsp_bus.draw_valid));
      check_field("draw_line", 10'(want.draw_line), 10'(rsp_bus.draw_line));
      check_field("vblank_request", 10'(want.vblank_request),
                  10'(rsp_bus.vblank_request));
      check_field("frame_done", 10'(want.frame_done), 10'(rsp_bus.frame_done));
      check_field("stat_flag_clear", 10'(want.stat_flag_clear),
                  10'(rsp_bus.stat_flag_clear));
      check_field("line_changed", 10'(want.line_changed), 10'(rsp_bus.line_changed));
      check_field("clocks_to_next", want.clocks_to_next, rsp_bus.clocks_to_next);
   endtask

   task automatic send_word(input req_word_type w, input logic typed,
                            input rsp_word_type want);
      rsp_word_type predicted;
      if (idling && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.req_type        <= w.req_type;
      req_bus.clock_increment <= w.clock_increment;
      req_bus.lcd_enable      <= w.lcd_enable;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = predict_status(w);
      expected_status.push_back(typed ? want : predicted);
   endtask

   task automatic csr_access(input logic write, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= {REG_DOUBLE_SPEED, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_double_speed(input logic value);
      logic [31:0] rdata;
      req_bus.valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_access(1'b1, {31'd0, value}, rdata);
      pred_double = value;
      @(posedge clock);
      csr_access(1'b0, 32'd0, rdata);
      if (rdata !== {31'd0, value}) begin
         $error("double_speed readback: expected %0d, actual %0d", value, rdata);
         failures++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // Receiver: checks each accepted word, then picks the next ready value.
   initial begin
      int stall_left;
      int hold_left;
      int holds_seen;
      stall_left = 0;
      hold_left  = 0;
      holds_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) check_result();
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = LONG_HOLD;
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      req_word_type w;
      int           counted;
      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.req_type        <= REQ_ADVANCE;
      req_bus.clock_increment <= 8'd0;
      req_bus.lcd_enable      <= 1'b0;
      psel                    <= 1'b0;
      penable                 <= 1'b0;
      pwrite                  <= 1'b0;
      paddr                   <= 3'd0;
      pwdata                  <= 32'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Off after reset, power-up, one full visible line, toggles, and a
      // lowered speed that leaves a threshold already passed.
      dir_rows.push_back(word_row(REQ_ADVANCE, 255, 1'b1, 1'b1,
                                  status(MODE_HBLANK, 8'd0, 1'b0, 1'b0, NO_EVENT)));
      dir_rows.push_back(word_row(REQ_ENABLE, 0, 1'b0, 1'b1,
                                  status(MODE_HBLANK, 8'd0, 1'b0, 1'b0, NO_EVENT)));
      dir_rows.push_back(word_row(REQ_ENABLE, 255, 1'b1, 1'b1,
                                  status(MODE_VBLANK, 8'd0, 1'b1, 1'b0, 10'd0)));
      dir_rows.push_back(word_row(REQ_ADVANCE, 0, 1'b0, 1'b1,
                                  status(MODE_OAM, 8'd0, 1'b0, 1'b0, 10'd82)));
      dir_rows.push_back(word_row(REQ_ADVANCE, 81, 1'b0, 1'b0, '0));
      dir_rows.push_back(word_row(REQ_ADVANCE, 1, 1'b1, 1'b0, '0));
      dir_rows.push_back(word_row(REQ_ADVANCE, 170, 1'b0, 1'b0, '0));
      dir_rows.push_back(word_row(REQ_ADVANCE, 204, 1'b0, 1'b0, '0));
      dir_rows.push_back(word_row(REQ_ADVANCE, 3, 1'b0, 1'b0, '0));
      dir_rows.push_back(word_row(REQ_ADVANCE, 1, 1'b0, 1'b0, '0));
      dir_rows.push_back(word_row(REQ_ADVANCE, 255, 1'b1, 1'b0, '0));
      dir_rows.push_back(word_row(REQ_ADVANCE, 255, 1'b0, 1'b0, '0));
      dir_rows.push_back(word_row(REQ_ENABLE, 0, 1'b1, 1'b0, '0));
      dir_rows.push_back(word_row(REQ_ENABLE, 255, 1'b0, 1'b1,
                                  status(MODE_HBLANK, 8'd0, 1'b1, 1'b1, NO_EVENT)));
      dir_rows.push_back(word_row(REQ_ADVANCE, 128, 1'b0, 1'b1,
                                  status(MODE_HBLANK, 8'd0, 1'b0, 1'b0, NO_EVENT)));
      dir_rows.push_back(speed_row(1'b1));
      dir_rows.push_back(word_row(REQ_ENABLE, 0, 1'b1, 1'b1,
                                  status(MODE_VBLANK, 8'd0, 1'b1, 1'b0, 10'd456)));
      dir_rows.push_back(word_row(REQ_ADVANCE, 255, 1'b0, 1'b0, '0));
      dir_rows.push_back(speed_row(1'b0));
      dir_rows.push_back(word_row(REQ_ENABLE, 0, 1'b1, 1'b0, '0));
      dir_rows.push_back(word_row(REQ_ADVANCE, 0, 1'b0, 1'b0, '0));
      dir_rows.push_back(speed_row(1'b1));
      dir_rows.push_back(word_row(REQ_ADVANCE, 255, 1'b0, 1'b0, '0));
      dir_rows.push_back(word_row(REQ_ADVANCE, 255, 1'b1, 1'b0, '0));
      dir_rows.push_back(word_row(REQ_ENABLE, 0, 1'b0, 1'b0, '0));
      dir_rows.push_back(word_row(REQ_ENABLE, 0, 1'b1, 1'b0, '0));

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_DOUBLE_SPEED) begin
            set_double_speed(dir_rows[i].speed);
         end else begin
            send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         set_double_speed((p == NUM_PHASES - 1) ? 1'($urandom_range(0, 1)) : 1'(p % 2));
         idling  = (p != NUM_PHASES - 1);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            w = random_word();
            if ((w.req_type == REQ_ADVANCE) ? pred_lcd_on : (w.lcd_enable != pred_lcd_on)) begin
               counted++;
               if (counted == 40 && p % 2 == 1) hold_requests++;
            end
            send_word(w, 1'b0, '0);
         end
      end

      req_bus.valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);

      $display("Checked %0d result words: %0d line draws, %0d vblank entries, %0d frame wraps,",
               words_checked, draws_seen, vblanks_seen, frames_seen);
      $display("%0d enable toggles, both speed settings, random stalls and long hold-offs.",
               toggles_seen);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
